// File: src/lzfbd_pkg.sv
// ----------------------------------------------------------------------------
// lzfbd_pkg
// Shared types and constants for the LZSS flag-byte decompressor.
// ----------------------------------------------------------------------------
`default_nettype none

package lzfbd_pkg;

    localparam int WINDOW_DEPTH_C = 2048;
    localparam int BYTE_W         = 8;
    localparam int LEN_FIELD_W    = 5;
    localparam int DIST_W         = 11;
    localparam int CLEN_W         = 16;
    localparam int COUNT_W        = 6;
    localparam int FLAGS_LEFT_W   = 4;

    localparam logic [COUNT_W-1:0]      LEN_BASE   = 6'd34;
    localparam logic [FLAGS_LEFT_W-1:0] FLAGS_FULL = 4'd8;
    localparam logic [CLEN_W-1:0]       CONS_MAX   = 16'hFFFF;

    // stream phase codes
    localparam logic [1:0] PH_FLAG = 2'd0;
    localparam logic [1:0] PH_ITEM = 2'd1;
    localparam logic [1:0] PH_LOW  = 2'd2;

    typedef struct packed {
        logic [BYTE_W-1:0] compressed_byte;
        logic              start_stream;
    } in_item_t;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              last;
        logic              stream_done;
        logic              bad_distance;
    } out_item_t;

endpackage

`default_nettype wire

// File: src/lzss_flag_byte_decompressor.sv
// ----------------------------------------------------------------------------
// lzss_flag_byte_decompressor
// LZSS decoder: flag bytes select literals or 16-bit copy tokens over a
// history window kept in a synchronous RAM.
//
//   channel | direction | signals                      | payload
//   cfg     | in        | cfg_valid/cfg_ready          | cfg_data (compressed length)
//   byte    | in        | byte_valid/byte_ready        | byte_data (in_item_t)
//   res     | out       | res_valid/res_ready          | res_data (out_item_t)
//
// Flag, token-high and ignored bytes fill no result slot; literals and bad
// distances each fill one result slot.
// A copy of length L emits L bytes after the token: each byte is one
// history read step followed by one write/emit step on the single RAM.
// Reset clears control state only; history is valid once written.
// A stalled result holds the copy engine in its write cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module lzss_flag_byte_decompressor #(
    parameter int WINDOW_DEPTH = lzfbd_pkg::WINDOW_DEPTH_C
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [lzfbd_pkg::CLEN_W-1:0]        cfg_data,
    input  wire logic                                byte_valid,
    output logic                                     byte_ready,
    input  wire lzfbd_pkg::in_item_t                 byte_data,
    output logic                                     res_valid,
    input  wire logic                                res_ready,
    output lzfbd_pkg::out_item_t                     res_data
);

    import lzfbd_pkg::*;

    localparam int AW = $clog2(WINDOW_DEPTH);
    localparam int CW = AW + 1;

    localparam logic [1:0] ST_IDLE    = 2'd0;
    localparam logic [1:0] ST_COPY_RD = 2'd1;
    localparam logic [1:0] ST_COPY_WR = 2'd2;

    logic [1:0]              state_reg, state_next;
    logic [CLEN_W-1:0]       clen_reg;
    logic [AW-1:0]           wp_reg, wp_next;
    logic [CW-1:0]           prod_reg, prod_next;
    logic [BYTE_W-1:0]       flag_reg, flag_next;
    logic [FLAGS_LEFT_W-1:0] left_reg, left_next;
    logic [BYTE_W-1:0]       thigh_reg, thigh_next;
    logic [1:0]              phase_reg, phase_next;
    logic [CLEN_W-1:0]       cons_reg, cons_next;
    logic                    fin_reg, fin_next;
    logic [AW-1:0]           src_reg, src_next;
    logic [COUNT_W-1:0]      cnt_reg, cnt_next;
    logic                    cdone_reg, cdone_next;
    logic                    res_valid_reg, res_valid_next;
    out_item_t               res_reg, res_next;

    logic                    out_free;
    logic                    accept;
    logic                    ram_we, ram_re;
    logic [AW-1:0]           ram_waddr;
    logic [BYTE_W-1:0]       ram_wdata, ram_rdata;

    logic [AW-1:0]           e_wp;
    logic [CW-1:0]           e_prod;
    logic [BYTE_W-1:0]       e_flag, e_thigh;
    logic [FLAGS_LEFT_W-1:0] e_left, left_dec;
    logic [1:0]              e_phase;
    logic [CLEN_W-1:0]       e_cons, cons_inc;
    logic                    e_fin, done_hit;
    logic [DIST_W-1:0]       copy_dist;
    logic [LEN_FIELD_W-1:0]  len_field;
    logic [BYTE_W-1:0]       b;

    lzfbd_ram #(
        .WIDTH(BYTE_W),
        .DEPTH(WINDOW_DEPTH)
    ) u_hist (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .re   (ram_re),
        .raddr(src_reg),
        .rdata(ram_rdata)
    );

    assign cfg_ready  = 1'b1;
    assign out_free   = !res_valid_reg || res_ready;
    assign byte_ready = (state_reg == ST_IDLE) && out_free;
    assign accept     = byte_valid && byte_ready;
    assign res_valid  = res_valid_reg;
    assign res_data   = res_reg;

    // stream state as seen by this request, after an optional restart
    always_comb
    begin
        b         = byte_data.compressed_byte;
        e_wp      = byte_data.start_stream ? '0 : wp_reg;
        e_prod    = byte_data.start_stream ? '0 : prod_reg;
        e_flag    = byte_data.start_stream ? '0 : flag_reg;
        e_left    = byte_data.start_stream ? '0 : left_reg;
        e_thigh   = byte_data.start_stream ? '0 : thigh_reg;
        e_phase   = byte_data.start_stream ? PH_FLAG : phase_reg;
        e_cons    = byte_data.start_stream ? '0 : cons_reg;
        e_fin     = byte_data.start_stream ? 1'b0 : fin_reg;
        cons_inc  = (e_cons != CONS_MAX) ? e_cons + 1'b1 : e_cons;
        left_dec  = (e_left != '0) ? e_left - 1'b1 : e_left;
        done_hit  = (cons_inc >= clen_reg);
        copy_dist = {e_thigh[DIST_W-BYTE_W-1:0], b};
        len_field = e_thigh[BYTE_W-1 -: LEN_FIELD_W];
    end

    always_comb
    begin
        state_next     = state_reg;
        wp_next        = wp_reg;
        prod_next      = prod_reg;
        flag_next      = flag_reg;
        left_next      = left_reg;
        thigh_next     = thigh_reg;
        phase_next     = phase_reg;
        cons_next      = cons_reg;
        fin_next       = fin_reg;
        src_next       = src_reg;
        cnt_next       = cnt_reg;
        cdone_next     = cdone_reg;
        res_valid_next = res_valid_reg && !res_ready;
        res_next       = res_reg;
        ram_we         = 1'b0;
        ram_re         = 1'b0;
        ram_waddr      = wp_reg;
        ram_wdata      = ram_rdata;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    wp_next    = e_wp;
                    prod_next  = e_prod;
                    flag_next  = e_flag;
                    left_next  = e_left;
                    thigh_next = e_thigh;
                    phase_next = e_phase;
                    cons_next  = e_cons;
                    fin_next   = e_fin;
                    if (!e_fin)
                    begin
                        case (e_phase)
                            PH_ITEM:
                            begin
                                cons_next = cons_inc;
                                if (e_flag[BYTE_W-1])
                                begin
                                    thigh_next = b;
                                    phase_next = PH_LOW;
                                end
                                else
                                begin
                                    ram_we    = 1'b1;
                                    ram_waddr = e_wp;
                                    ram_wdata = b;
                                    wp_next   = e_wp + 1'b1;
                                    prod_next = (e_prod < CW'(WINDOW_DEPTH)) ?
                                                e_prod + 1'b1 : e_prod;
                                    res_valid_next       = 1'b1;
                                    res_next.out_byte     = b;
                                    res_next.last         = 1'b1;
                                    res_next.stream_done  = done_hit;
                                    res_next.bad_distance = 1'b0;
                                    flag_next  = {e_flag[BYTE_W-2:0], 1'b0};
                                    left_next  = left_dec;
                                    phase_next = (left_dec != '0) ? PH_ITEM : PH_FLAG;
                                    fin_next   = done_hit;
                                end
                            end
                            PH_LOW:
                            begin
                                cons_next  = cons_inc;
                                flag_next  = {e_flag[BYTE_W-2:0], 1'b0};
                                left_next  = left_dec;
                                phase_next = (left_dec != '0) ? PH_ITEM : PH_FLAG;
                                fin_next   = done_hit;
                                if ((copy_dist == '0) || (CW'(copy_dist) > e_prod))
                                begin
                                    res_valid_next        = 1'b1;
                                    res_next.out_byte     = '0;
                                    res_next.last         = 1'b1;
                                    res_next.stream_done  = done_hit;
                                    res_next.bad_distance = 1'b1;
                                end
                                else
                                begin
                                    src_next   = e_wp - AW'(copy_dist);
                                    cnt_next   = LEN_BASE - COUNT_W'(len_field);
                                    cdone_next = done_hit;
                                    state_next = ST_COPY_RD;
                                end
                            end
                            default:
                            begin
                                if (e_cons >= clen_reg)
                                begin
                                    fin_next = 1'b1;
                                end
                                else
                                begin
                                    cons_next  = cons_inc;
                                    flag_next  = b;
                                    left_next  = FLAGS_FULL;
                                    phase_next = PH_ITEM;
                                end
                            end
                        endcase
                    end
                end
            end
            ST_COPY_RD:
            begin
                ram_re     = 1'b1;
                src_next   = src_reg + 1'b1;
                state_next = ST_COPY_WR;
            end
            ST_COPY_WR:
            begin
                if (out_free)
                begin
                    ram_we                = 1'b1;
                    ram_waddr             = wp_reg;
                    ram_wdata             = ram_rdata;
                    wp_next               = wp_reg + 1'b1;
                    prod_next             = (prod_reg < CW'(WINDOW_DEPTH)) ?
                                            prod_reg + 1'b1 : prod_reg;
                    res_valid_next        = 1'b1;
                    res_next.out_byte     = ram_rdata;
                    res_next.last         = (cnt_reg == COUNT_W'(1));
                    res_next.stream_done  = cdone_reg;
                    res_next.bad_distance = 1'b0;
                    cnt_next              = cnt_reg - 1'b1;
                    state_next            = (cnt_reg == COUNT_W'(1)) ? ST_IDLE : ST_COPY_RD;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            clen_reg      <= '0;
            wp_reg        <= '0;
            prod_reg      <= '0;
            flag_reg      <= '0;
            left_reg      <= '0;
            thigh_reg     <= '0;
            phase_reg     <= PH_FLAG;
            cons_reg      <= '0;
            fin_reg       <= 1'b0;
            cnt_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                clen_reg <= cfg_data;
            end
            wp_reg        <= wp_next;
            prod_reg      <= prod_next;
            flag_reg      <= flag_next;
            left_reg      <= left_next;
            thigh_reg     <= thigh_next;
            phase_reg     <= phase_next;
            cons_reg      <= cons_next;
            fin_reg       <= fin_next;
            cnt_reg       <= cnt_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        src_reg   <= src_next;
        cdone_reg <= cdone_next;
        res_reg   <= res_next;
    end

`ifndef NO_ASSERTIONS
    a_wr_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_COPY_WR && !out_free) |=> state_reg == ST_COPY_WR)
        else $error("copy write left while result slot busy");

    a_prod_sat: assert property (@(posedge clk) disable iff (!rst_n)
        prod_reg <= CW'(WINDOW_DEPTH))
        else $error("produced count beyond window");

    a_rd_count: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_COPY_RD |-> cnt_reg != '0)
        else $error("copy read with no bytes left");

    a_copy_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_COPY_WR && out_free && cnt_reg == COUNT_W'(1))
        |=> (state_reg == ST_IDLE && res_valid_reg && res_reg.last))
        else $error("copy end not flagged last");
`endif

endmodule

`default_nettype wire

// File: src/lzfbd_ram.sv
// ----------------------------------------------------------------------------
// lzfbd_ram
// Generic simple dual-port RAM, one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module lzfbd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire
